// File: src/cbr_pkg.sv
`default_nettype none

package cbr_pkg;

    // Channel layout of one incoming pixel
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_in_pix;

    // One blurred pixel with its position
    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic [9:0]  out_col;
        logic [11:0] out_row;
        logic        run_end;
    } t_out_pix;

    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int NUM_TERMS  = 5;
    localparam int CNT_W      = 3;
    localparam int SUM_W      = 11;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int OCOL_W     = 10;
    localparam int OROW_W     = 12;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Which result of the current pixel is being formed
    typedef enum logic [1:0] {
        SLOT_ABOVE,
        SLOT_LEFT,
        SLOT_SELF
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        logic  latch_first;
        logic  latch_second;
        logic  sum;
        logic  divide;
        logic  advance;
        t_slot slot;
        logic  run_end;
    } t_dp_cmd;

    // Datapath to controller: which results the current pixel causes
    typedef struct packed {
        logic en_above;
        logic en_left;
        logic en_self;
    } t_dp_status;

    // Reciprocal of a neighbour count, scaled by 2**RECIP_SHIFT and rounded up;
    // exact for every sum below 2**SUM_W
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21846;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13108;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/cbr_ram.sv
`default_nettype none

module cbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: src/cbr_ctrl.sv
`default_nettype none

module cbr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_out_stall,
    input  wire cbr_pkg::t_dp_status i_status,
    output logic                     o_in_stall,
    output logic                     o_cfg_ready,
    output logic                     o_out_valid,
    output cbr_pkg::t_dp_cmd         o_cmd
);

    import cbr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ0,
        ST_READ1,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_slot  r_slot, n_slot;

    logic  have_first, have_next;
    t_slot first_slot, next_slot;

    // First result slot of the pixel
    always_comb begin
        have_first = i_status.en_above | i_status.en_left | i_status.en_self;
        if (i_status.en_above) begin
            first_slot = SLOT_ABOVE;
        end else if (i_status.en_left) begin
            first_slot = SLOT_LEFT;
        end else begin
            first_slot = SLOT_SELF;
        end
    end

    // Slot that follows the current one, if any
    always_comb begin
        have_next = 1'b0;
        next_slot = SLOT_SELF;
        case (r_slot)
            SLOT_ABOVE: begin
                have_next = i_status.en_left | i_status.en_self;
                next_slot = i_status.en_left ? SLOT_LEFT : SLOT_SELF;
            end
            SLOT_LEFT: begin
                have_next = i_status.en_self;
                next_slot = SLOT_SELF;
            end
            default: begin
                have_next = 1'b0;
                next_slot = SLOT_SELF;
            end
        endcase
    end

    // Sequence one pixel: two line store reads, then one result at a time
    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        o_cmd        = '0;
        o_cmd.slot   = r_slot;
        o_cmd.run_end = ~have_next;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ0;
                end
            end
            ST_READ0: begin
                o_cmd.latch_first = 1'b1;
                n_state           = ST_READ1;
            end
            ST_READ1: begin
                o_cmd.latch_second = 1'b1;
                if (have_first) begin
                    n_slot  = first_slot;
                    n_state = ST_SUM;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.divide = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    if (have_next) begin
                        n_slot  = next_slot;
                        n_state = ST_SUM;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and current slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= SLOT_ABOVE;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE) | i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

endmodule

`default_nettype wire

// File: src/cbr_datapath.sv
`default_nettype none

module cbr_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire cbr_pkg::t_in_pix               i_in_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [cbr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire cbr_pkg::t_dp_cmd               i_cmd,
    output cbr_pkg::t_dp_status                 o_status,
    output cbr_pkg::t_out_pix                   o_out_data
);

    import cbr_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCMP_W = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;

    // Configuration and position
    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]        r_col;
    logic [CFG_HEIGHT_W-1:0] r_row;
    logic [PIX_W-1:0]        r_rec0, r_rec1;

    // Pixel under work and line store words
    logic [PIX_W-1:0] r_cur, r_a0, r_t0, r_a1, r_tm;
    logic [PIX_W-1:0] ra_rd_data, rt_rd_data;
    logic [COL_W-1:0] ra_rd_addr, rt_rd_addr;

    // Result forming
    logic [SUM_W-1:0]  r_sum [NUM_CHAN];
    logic [CNT_W-1:0]  r_cnt;
    logic [OCOL_W-1:0] r_ocol;
    logic [OROW_W-1:0] r_orow;
    t_out_pix          r_out;

    logic [WCMP_W-1:0]       width_ext;
    logic [COL_W-1:0]        last_col;
    logic [CFG_HEIGHT_W-1:0] last_row_idx;
    logic                    on_last_row, col_first, col_last;

    logic [PIX_W-1:0]  term [NUM_TERMS];
    logic              term_en [NUM_TERMS];
    logic [SUM_W-1:0]  n_sum [NUM_CHAN];
    logic [CNT_W-1:0]  n_cnt;
    logic [OCOL_W-1:0] n_ocol;
    logic [OROW_W-1:0] n_orow;
    logic [SUM_W+RECIP_W-1:0] prod [NUM_CHAN];
    logic [RECIP_W-1:0] rcp;

    // Effective frame size
    always_comb begin
        width_ext = WCMP_W'(r_width);
        if (width_ext == '0) begin
            last_col = '0;
        end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(width_ext - WCMP_W'(1));
        end
        last_row_idx = (r_height == '0) ? '0 : r_height - 12'd1;
    end

    assign on_last_row = (r_row == last_row_idx);
    assign col_first   = (r_col == '0);
    assign col_last    = (r_col == last_col);

    assign o_status.en_above = (r_row != '0);
    assign o_status.en_left  = on_last_row & ~col_first;
    assign o_status.en_self  = on_last_row & col_last;

    // Line stores: current row and the row before it
    assign ra_rd_addr = i_cmd.latch_first ? r_col + COL_W'(1) : r_col;
    assign rt_rd_addr = i_cmd.latch_first ? r_col - COL_W'(1) : r_col;

    cbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.latch_second),
        .i_wr_addr (r_col),
        .i_wr_data (r_cur),
        .i_rd_addr (ra_rd_addr),
        .o_rd_data (ra_rd_data)
    );

    cbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.latch_second),
        .i_wr_addr (r_col),
        .i_wr_data (r_a0),
        .i_rd_addr (rt_rd_addr),
        .o_rd_data (rt_rd_data)
    );

    // Capture pixel and line store words
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur <= i_in_data;
        end
        if (i_cmd.latch_first) begin
            r_a0 <= ra_rd_data;
            r_t0 <= rt_rd_data;
        end
        if (i_cmd.latch_second) begin
            r_a1 <= ra_rd_data;
            r_tm <= rt_rd_data;
        end
    end

    // Pick the cross terms of the current result
    always_comb begin
        for (int i = 0; i < NUM_TERMS; i++) begin
            term[i]    = '0;
            term_en[i] = 1'b0;
        end
        n_ocol = OCOL_W'(r_col);
        n_orow = r_row;
        case (i_cmd.slot)
            SLOT_ABOVE: begin
                term[0] = r_a0;  term_en[0] = 1'b1;
                term[1] = r_a1;  term_en[1] = ~col_last;
                term[2] = r_cur; term_en[2] = 1'b1;
                term[3] = r_tm;  term_en[3] = ~col_first;
                term[4] = r_t0;  term_en[4] = (r_row > 12'd1);
                n_orow  = r_row - 12'd1;
            end
            SLOT_LEFT: begin
                term[0] = r_rec0; term_en[0] = 1'b1;
                term[1] = r_cur;  term_en[1] = 1'b1;
                term[2] = r_rec1; term_en[2] = (r_col > COL_W'(1));
                term[3] = r_tm;   term_en[3] = (r_row != '0);
                n_ocol  = OCOL_W'(r_col - COL_W'(1));
            end
            SLOT_SELF: begin
                term[0] = r_cur;  term_en[0] = 1'b1;
                term[1] = r_rec0; term_en[1] = ~col_first;
                term[2] = r_a0;   term_en[2] = (r_row != '0);
            end
            default: begin
                term[0] = r_cur;  term_en[0] = 1'b1;
            end
        endcase
    end

    // Add the selected terms channel by channel
    always_comb begin
        n_cnt = '0;
        for (int i = 0; i < NUM_TERMS; i++) begin
            n_cnt = n_cnt + CNT_W'(term_en[i]);
        end
        for (int k = 0; k < NUM_CHAN; k++) begin
            n_sum[k] = '0;
            for (int i = 0; i < NUM_TERMS; i++) begin
                if (term_en[i]) begin
                    n_sum[k] = n_sum[k] + SUM_W'(term[i][(NUM_CHAN-1-k)*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
        end
    end

    // Divide by the neighbour count through its reciprocal
    assign rcp = recip(r_cnt);

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            prod[k] = (SUM_W+RECIP_W)'(r_sum[k]) * (SUM_W+RECIP_W)'(rcp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.divide) begin
            r_out.out_red   <= prod[0][RECIP_SHIFT +: CHAN_W];
            r_out.out_green <= prod[1][RECIP_SHIFT +: CHAN_W];
            r_out.out_blue  <= prod[2][RECIP_SHIFT +: CHAN_W];
            r_out.out_alpha <= prod[3][RECIP_SHIFT +: CHAN_W];
            r_out.out_col   <= r_ocol;
            r_out.out_row   <= r_orow;
            r_out.run_end   <= i_cmd.run_end;
        end
    end

    assign o_out_data = r_out;

    // Configuration writes restart the frame; finished pixels advance it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_rec0   <= '0;
            r_rec1   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                default:          r_width  <= r_width;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_rec0 <= '0;
            r_rec1 <= '0;
        end else if (i_cmd.advance) begin
            r_rec1 <= r_rec0;
            r_rec0 <= r_cur;
            if (!col_last) begin
                r_col <= r_col + COL_W'(1);
            end else begin
                r_col <= '0;
                r_row <= on_last_row ? '0 : r_row + 12'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/cross_blur_rgba_stream.sv
// Five-point cross mean blur for a raster-order RGBA pixel stream. Each pixel
// comes out as the truncated per-channel mean of itself and its in-image up,
// down, left and right neighbours, tagged with its column, row and a run-end
// flag on the last result of each input. Output of a row trails its input by
// one row; on the last row each input also releases the pixel before it, and
// the last input of the frame releases itself. A pixel has 0 to 3 results,
// and the next pixel is not taken until all of them are out: each line store
// has one read port and is read twice per pixel, and one set of four channel
// multipliers forms the results one after another. Writing either register
// restarts the frame at row 0, column 0; line store contents are kept. Line
// stores are MAX_WIDTH pixels deep.
`default_nettype none

module cross_blur_rgba_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire cbr_pkg::t_in_pix               i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output cbr_pkg::t_out_pix                   o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cbr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cbr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import cbr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       cfg_we;

    assign cfg_we = i_cfg_valid & o_cfg_ready;

    cbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cbr_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: src/cbr_checker.sv
`default_nettype none

module cbr_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire cbr_pkg::t_out_pix              o_out_data,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready
);

    import cbr_pkg::*;

    logic in_xfer, out_xfer, cfg_xfer;

    assign in_xfer  = i_in_valid & ~o_in_stall;
    assign out_xfer = o_out_valid & ~i_out_stall;
    assign cfg_xfer = i_cfg_valid & o_cfg_ready;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // Take a pixel only when no result is pending
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> !o_out_valid)
        else $error("pixel taken while a result is pending");

    // Busy right after a pixel transfer
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (o_in_stall && !o_cfg_ready))
        else $error("second pixel or register write accepted during work");

    // Drop valid after the last result of a pixel
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_data.run_end) |=> !o_out_valid)
        else $error("result after run end");

    // Take register writes only when no result is pending and no pixel is taken
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_xfer |-> (!o_out_valid && !in_xfer))
        else $error("register write during work");

endmodule

bind cross_blur_rgba_stream cbr_checker u_checker (.*);

`default_nettype wire
